### rtl/core/pressure_module_response_deframer_top_assert.svh
// Assertion macros used by the deframer parser.
// Each macro expands to one labeled concurrent assertion on clk_i; PMRD_ASSERT is also disabled by rst_ni.
`ifndef PRESSURE_MODULE_RESPONSE_DEFRAMER_TOP_ASSERT_SVH
`define PRESSURE_MODULE_RESPONSE_DEFRAMER_TOP_ASSERT_SVH

// Checked only while the block is out of reset.
`define PMRD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define PMRD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/pmrd_pkg.sv
// Shared types and constants for the pressure module response deframer.
// No dependencies; imported by every module of the block.
package pmrd_pkg;

  localparam logic [7:0] HeaderReset = 8'h3E;
  localparam logic [7:0] LenPressure = 8'h05;
  localparam logic [7:0] LenResult   = 8'h18;
  localparam logic [7:0] LenAck      = 8'h04;

  typedef enum logic [1:0] {
    KIND_PRESSURE = 2'd0,
    KIND_RESULT   = 2'd1,
    KIND_ACK      = 2'd2
  } pmrd_kind_e;

  // One registered received byte on its way to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } pmrd_byte_t;

endpackage

### rtl/core/pressure_module_response_deframer_top.sv
// Pressure module response deframer: byte stream in, one result per good frame out.
// Receives rx bytes on a valid/ready channel and decodes response frames.
// Channels: in (in_valid_i, in_ready_o, rx_byte_i) carries one byte per request.
// out (out_valid_o, out_ready_i, frame_kind_o and the readings) carries one
// result per frame that has a known length and a zero checksum; every result
// holds all five latest readings, and ack_code_o is zero unless the frame is
// an acknowledge request. cfg (cfg_valid_i, cfg_ready_o, header_value_i) sets
// the start byte; it is always ready and should only be written while idle.
// Throughput: one byte per cycle while no result waits on out_ready_i, set by the
// single parse stage between the input register and the result register.
// Path: the last byte of a frame goes from the input register through the parse
// stage into the result register, provided no earlier result is still waiting.
// Reset: the parser returns to header hunt, all readings clear to zero and the
// start byte returns to 0x3E; no clearing pass is needed.
// Stall: while a result waits on out_ready_i, one more byte is held in the
// input register and then in_ready_o drops until the result is taken.
module pressure_module_response_deframer_top
  import pmrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  header_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_kind_o,
  output logic [15:0] cuff_pressure_o,
  output logic [15:0] systolic_o,
  output logic [15:0] diastolic_o,
  output logic [15:0] mean_pressure_o,
  output logic [15:0] pulse_rate_o,
  output logic [7:0]  ack_code_o
);

  logic [7:0] header_q, header_d;
  pmrd_byte_t rx_byte;
  logic       advance;

  assign cfg_ready_o = 1'b1;
  assign header_d    = (cfg_valid_i && cfg_ready_o) ? header_value_i : header_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HeaderReset;
    end else begin
      header_q <= header_d;
    end
  end

  pmrd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .byte_o     (rx_byte)
  );

  pmrd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_i          (rx_byte),
    .header_i        (header_q),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_kind_o    (frame_kind_o),
    .cuff_pressure_o (cuff_pressure_o),
    .systolic_o      (systolic_o),
    .diastolic_o     (diastolic_o),
    .mean_pressure_o (mean_pressure_o),
    .pulse_rate_o    (pulse_rate_o),
    .ack_code_o      (ack_code_o)
  );

endmodule

### rtl/core/pmrd_in_reg.sv
// Input register of the deframer: takes one received byte per request.
// Depends on pmrd_pkg for the byte struct.
module pmrd_in_reg
  import pmrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output pmrd_byte_t byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  // The stage frees up in the same cycle that the parser consumes it.
  assign in_ready_o = !valid_q || advance_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= rx_byte_i;
    end
  end

  assign byte_o = '{valid: valid_q, data: data_q};

endmodule

### rtl/core/pmrd_parser.sv
// Frame parser and result register of the deframer.
// Depends on pmrd_pkg and on the assertion macro header.
module pmrd_parser
  import pmrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pmrd_byte_t  byte_i,
  input  logic [7:0]  header_i,
  output logic        advance_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_kind_o,
  output logic [15:0] cuff_pressure_o,
  output logic [15:0] systolic_o,
  output logic [15:0] diastolic_o,
  output logic [15:0] mean_pressure_o,
  output logic [15:0] pulse_rate_o,
  output logic [7:0]  ack_code_o
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [4:0]  len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] pressure_q, pressure_d;
  logic [15:0] systolic_q, systolic_d;
  logic [15:0] diastolic_q, diastolic_d;
  logic [15:0] mean_q, mean_d;
  logic [15:0] pulse_q, pulse_d;
  pmrd_kind_e  kind_q, kind_d;
  logic [7:0]  ack_q, ack_d;

  // Only the payload bytes that feed a reading are kept.
  logic [7:0] b2_q, b3_q, b4_q, b5_q, b16_q, b17_q, b18_q, b19_q;

  logic       step;
  logic [7:0] b;
  logic [7:0] sum_add;
  logic [4:0] pos_inc;
  logic       len_known;
  logic       hit;

  assign advance_o = !out_valid_q || out_ready_i;
  assign step      = byte_i.valid && advance_o;
  assign b         = byte_i.data;
  assign sum_add   = sum_q + b;
  assign pos_inc   = pos_q + 5'd1;
  assign len_known = (b == LenPressure) || (b == LenResult) || (b == LenAck);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    len_d       = len_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    pressure_d  = pressure_q;
    systolic_d  = systolic_q;
    diastolic_d = diastolic_q;
    mean_d      = mean_q;
    pulse_d     = pulse_q;
    kind_d      = kind_q;
    ack_d       = ack_q;
    hit         = 1'b0;
    if (advance_o) begin
      out_valid_d = 1'b0;
    end
    if (step) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (b == header_i) begin
            sum_d   = b;
            pos_d   = 5'd1;
            phase_d = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (len_known) begin
            sum_d   = sum_add;
            len_d   = b[4:0];
            pos_d   = 5'd2;
            phase_d = PH_BODY;
          end else begin
            sum_d   = '0;
            pos_d   = '0;
            len_d   = '0;
            phase_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          sum_d = sum_add;
          pos_d = pos_inc;
          if (pos_inc >= len_q) begin
            hit     = (sum_add == 8'h00);
            sum_d   = '0;
            pos_d   = '0;
            len_d   = '0;
            phase_d = PH_HUNT;
          end
        end
        default: begin
          sum_d   = '0;
          pos_d   = '0;
          len_d   = '0;
          phase_d = PH_HUNT;
        end
      endcase
    end
    // A good checksum updates the readings and loads the result register.
    if (hit) begin
      out_valid_d = 1'b1;
      ack_d       = 8'h00;
      if (len_q == LenPressure[4:0]) begin
        kind_d     = KIND_PRESSURE;
        pressure_d = {b3_q, b2_q};
      end else if (len_q == LenResult[4:0]) begin
        kind_d      = KIND_RESULT;
        systolic_d  = {b3_q, b2_q};
        diastolic_d = {b5_q, b4_q};
        mean_d      = {b17_q, b16_q};
        pulse_d     = {b19_q, b18_q};
      end else begin
        kind_d = KIND_ACK;
        ack_d  = b2_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      pos_q       <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
      pressure_q  <= '0;
      systolic_q  <= '0;
      diastolic_q <= '0;
      mean_q      <= '0;
      pulse_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      pressure_q  <= pressure_d;
      systolic_q  <= systolic_d;
      diastolic_q <= diastolic_d;
      mean_q      <= mean_d;
      pulse_q     <= pulse_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    ack_q  <= ack_d;
    if (step && phase_q == PH_BODY) begin
      case (pos_q)
        5'd2:    b2_q  <= b;
        5'd3:    b3_q  <= b;
        5'd4:    b4_q  <= b;
        5'd5:    b5_q  <= b;
        5'd16:   b16_q <= b;
        5'd17:   b17_q <= b;
        5'd18:   b18_q <= b;
        5'd19:   b19_q <= b;
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_kind_o    = kind_q;
  assign cuff_pressure_o = pressure_q;
  assign systolic_o      = systolic_q;
  assign diastolic_o     = diastolic_q;
  assign mean_pressure_o = mean_q;
  assign pulse_rate_o    = pulse_q;
  assign ack_code_o      = ack_q;

`include "pressure_module_response_deframer_top_assert.svh"

  `PMRD_ASSERT(a_hunt_clean, (phase_q == PH_HUNT) |-> (pos_q == 5'd0 && sum_q == 8'h00), "hunt phase carries frame state")
  `PMRD_ASSERT(a_body_bounds, (phase_q == PH_BODY) |-> ((len_q == LenPressure[4:0] || len_q == LenResult[4:0] || len_q == LenAck[4:0]) && pos_q < len_q), "body position outside declared length")
  `PMRD_ASSERT(a_hit_loads, hit |=> out_valid_q, "accepted frame produced no result")
  `PMRD_ASSERT(a_ack_zero, (out_valid_q && kind_q != KIND_ACK) |-> (ack_q == 8'h00), "ack code set on a reading result")

endmodule

### dv/pressure_module_response_deframer_top_tb.sv
// Self-checking testbench for the pressure module response deframer.
// Drives framed and broken byte streams with random idling on both sides and compares
// each decoded result with a local frame decoder; depends on pmrd_pkg and the top RTL.
module pressure_module_response_deframer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmrd_pkg::*;

  localparam int QuietLimit = 2000;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_BODY
  } parse_phase_e;

  typedef enum int {
    IDLE_NONE,
    IDLE_LIGHT,
    IDLE_FULL
  } idle_style_e;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    pmrd_kind_e  kind;
    logic [15:0] cuff;
    logic [15:0] sys;
    logic [15:0] dia;
    logic [15:0] mean;
    logic [15:0] pulse;
    logic [7:0]  ack;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  header_value = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_kind;
  logic [15:0] cuff_pressure;
  logic [15:0] systolic;
  logic [15:0] diastolic;
  logic [15:0] mean_pressure;
  logic [15:0] pulse_rate;
  logic [7:0]  ack_code;

  // Frame decoder state, kept in step with accepted requests.
  logic [7:0]   header_reg = HeaderReset;
  parse_phase_e parse_phase = PH_HUNT;
  logic [4:0]   byte_pos = '0;
  logic [7:0]   frame_len = '0;
  logic [7:0]   running_total = '0;
  logic [7:0]   frame_bytes [24];
  logic [15:0]  cuff_hold = '0;
  logic [15:0]  sys_hold = '0;
  logic [15:0]  dia_hold = '0;
  logic [15:0]  mean_hold = '0;
  logic [15:0]  pulse_hold = '0;

  logic [7:0]  rx_backlog [$];
  reading_t    expected_readings [$];
  int          bytes_queued = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          byte_gap = 0;
  int          result_stall = 0;
  bit          in_fired = 1'b0;
  idle_style_e in_style = IDLE_FULL;
  idle_style_e out_style = IDLE_FULL;

  pressure_module_response_deframer_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .header_value_i (header_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_kind_o   (frame_kind),
    .cuff_pressure_o(cuff_pressure),
    .systolic_o     (systolic),
    .diastolic_o    (diastolic),
    .mean_pressure_o(mean_pressure),
    .pulse_rate_o   (pulse_rate),
    .ack_code_o     (ack_code)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait(idle_style_e style);
    case (style)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
      default:    return $urandom_range(0, 17);
    endcase
  endfunction

  function automatic void restart_hunt();
    parse_phase   = PH_HUNT;
    byte_pos      = '0;
    frame_len     = '0;
    running_total = '0;
  endfunction

  function automatic bit is_known_length(logic [7:0] b);
    return (b == LenPressure) || (b == LenResult) || (b == LenAck);
  endfunction

  // Advances the decoder by one byte and queues the result of a good frame.
  function automatic void decode_byte(logic [7:0] b);
    reading_t want;
    case (parse_phase)
      PH_HUNT: begin
        if (b == header_reg) begin
          frame_bytes[0] = b;
          running_total  = b;
          byte_pos       = 5'd1;
          parse_phase    = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (is_known_length(b)) begin
          frame_bytes[1] = b;
          running_total  = running_total + b;
          frame_len      = b;
          byte_pos       = 5'd2;
          parse_phase    = PH_BODY;
        end else begin
          restart_hunt();
        end
      end
      default: begin
        frame_bytes[byte_pos] = b;
        running_total = running_total + b;
        byte_pos = byte_pos + 5'd1;
        if (byte_pos >= frame_len) begin
          if (running_total == 8'h00) begin
            want.ack = 8'h00;
            case (frame_len)
              LenPressure: begin
                want.kind = KIND_PRESSURE;
                cuff_hold = {frame_bytes[3], frame_bytes[2]};
              end
              LenResult: begin
                want.kind  = KIND_RESULT;
                sys_hold   = {frame_bytes[3], frame_bytes[2]};
                dia_hold   = {frame_bytes[5], frame_bytes[4]};
                mean_hold  = {frame_bytes[17], frame_bytes[16]};
                pulse_hold = {frame_bytes[19], frame_bytes[18]};
              end
              default: begin
                want.kind = KIND_ACK;
                want.ack  = frame_bytes[2];
              end
            endcase
            want.cuff  = cuff_hold;
            want.sys   = sys_hold;
            want.dia   = dia_hold;
            want.mean  = mean_hold;
            want.pulse = pulse_hold;
            expected_readings.push_back(want);
          end
          restart_hunt();
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Input driver: holds each request until it is taken, then idles for the drawn gap.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fired)) begin
      in_fired = 1'b0;
      if (byte_gap > 0) begin
        byte_gap--;
        in_valid <= 1'b0;
      end else if (rx_backlog.size() != 0) begin
        rx_byte  <= rx_backlog.pop_front();
        in_valid <= 1'b1;
        byte_gap = draw_wait(in_style);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_stall > 0) begin
        result_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor, decoder update and watchdog, all on the sampling edge.
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("result with no frame pending, kind %0d", frame_kind));
        end else begin
          want = expected_readings.pop_front();
          if (frame_kind !== want.kind)
            report_mismatch($sformatf("frame_kind %0d, want %0d", frame_kind, want.kind));
          if (cuff_pressure !== want.cuff)
            report_mismatch($sformatf("cuff_pressure %h, want %h", cuff_pressure, want.cuff));
          if (systolic !== want.sys)
            report_mismatch($sformatf("systolic %h, want %h", systolic, want.sys));
          if (diastolic !== want.dia)
            report_mismatch($sformatf("diastolic %h, want %h", diastolic, want.dia));
          if (mean_pressure !== want.mean)
            report_mismatch($sformatf("mean_pressure %h, want %h", mean_pressure, want.mean));
          if (pulse_rate !== want.pulse)
            report_mismatch($sformatf("pulse_rate %h, want %h", pulse_rate, want.pulse));
          if (ack_code !== want.ack)
            report_mismatch($sformatf("ack_code %h, want %h", ack_code, want.ack));
        end
        result_stall = draw_wait(out_style);
      end
      if (in_valid && in_ready) begin
        decode_byte(rx_byte);
        in_fired = 1'b1;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("TIMEOUT @%0t: no request moved for %0d cycles", $time, QuietLimit);
          $display("pressure_module_response_deframer_top verification failed");
          $finish;
        end
      end
    end
  end

  function automatic void push_byte(logic [7:0] b);
    rx_backlog.push_back(b);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] pick_length();
    case ($urandom_range(0, 2))
      0:       return LenPressure;
      1:       return LenResult;
      default: return LenAck;
    endcase
  endfunction

  // Queues one frame under the current header; a corrupted one has a nonzero sum.
  function automatic void push_frame(logic [7:0] len, fill_e fill, bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    push_byte(header_reg);
    push_byte(len);
    sum = header_reg + len;
    for (int i = 2; i < len - 1; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      push_byte(b);
      sum = sum + b;
    end
    b = -sum;
    if (corrupt)
      b = b + 8'($urandom_range(1, 255));
    push_byte(b);
  endfunction

  task automatic wait_until_idle();
    while (rx_backlog.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic pick_styles();
    in_style  = idle_style_e'($urandom_range(0, 2));
    out_style = idle_style_e'($urandom_range(0, 2));
  endtask

  task automatic write_header(input logic [7:0] h);
    @(negedge clk_i);
    cfg_valid    <= 1'b1;
    header_value <= h;
    @(posedge clk_i);
    while (!cfg_ready)
      @(posedge clk_i);
    header_reg = h;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Mostly good frames with random content, mixed with broken ones and line noise.
  task automatic random_traffic(input int budget);
    int         start;
    int         pick;
    int         n;
    logic [7:0] len;
    logic [7:0] b;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        push_frame(LenPressure, FILL_RANDOM, 1'b0);
      end else if (pick < 50) begin
        push_frame(LenAck, FILL_RANDOM, 1'b0);
      end else if (pick < 63) begin
        push_frame(LenResult, FILL_RANDOM, 1'b0);
      end else if (pick < 73) begin
        push_frame(pick_length(), FILL_RANDOM, 1'b1);
      end else if (pick < 81) begin
        push_byte(header_reg);
        do
          b = 8'($urandom);
        while (is_known_length(b));
        push_byte(b);
      end else if (pick < 90) begin
        // Truncated frame: the next frame's bytes land in its body.
        len = pick_length();
        push_byte(header_reg);
        push_byte(len);
        n = $urandom_range(0, len - 3);
        for (int i = 0; i < n; i++)
          push_byte(8'($urandom));
      end else begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          push_byte(8'($urandom));
      end
      // Now and then the sender holds off until every pending result is out.
      if ($urandom_range(0, 29) == 0) begin
        wait_until_idle();
        pick_styles();
      end
    end
  endtask

  initial begin
    logic [7:0] header_plan [5];
    header_plan = '{8'h00, 8'hFF, LenAck, 8'($urandom), HeaderReset};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bytes outside a frame, a length byte equal to the header, data extremes,
    // and a bad sum.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(header_reg);
    push_byte(header_reg);
    push_frame(LenPressure, FILL_ONES, 1'b0);
    push_frame(LenAck, FILL_ZERO, 1'b0);
    push_frame(LenAck, FILL_RANDOM, 1'b1);
    push_frame(LenPressure, FILL_ZERO, 1'b0);
    random_traffic(110);

    for (int p = 0; p < 5; p++) begin
      wait_until_idle();
      repeat (4) @(posedge clk_i);
      write_header(header_plan[p]);
      pick_styles();
      random_traffic(125);
    end

    wait_until_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("pressure_module_response_deframer_top verification clean");
    end else begin
      $display("pressure_module_response_deframer_top verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pmrd_pkg.sv
rtl/core/pmrd_in_reg.sv
rtl/core/pmrd_parser.sv
rtl/core/pressure_module_response_deframer_top.sv
dv/pressure_module_response_deframer_top_tb.sv
